/* rtl/gte_pkg.sv */
`default_nettype none

package gte_pkg;

    localparam int NV = 16;
    localparam int VW = $clog2(NV);
    localparam int CW = VW + 1;
    localparam int AW = 2 * VW;

    localparam logic [1:0] OP_CLEAR    = 2'd0;
    localparam logic [1:0] OP_ADD      = 2'd1;
    localparam logic [1:0] OP_TRAVERSE = 2'd2;

    localparam logic [CW-1:0] ROW_FULL = CW'(NV);

    typedef struct packed {
        logic [1:0]    operation;
        logic [VW-1:0] src_vertex;
        logic [VW-1:0] dest_vertex;
    } cmd_t;

    typedef struct packed {
        logic [VW-1:0] vertex;
        logic          last;
        logic          status;
    } res_t;

    typedef struct packed {
        logic          re;
        logic [AW-1:0] raddr;
        logic          we;
        logic [AW-1:0] waddr;
        logic [VW-1:0] wdata;
    } adj_req_t;

    typedef struct packed {
        logic [VW-1:0] v;
        logic [CW-1:0] nxt;
    } stk_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_B_NEXT,
        S_B_SCAN,
        S_D_TOP,
        S_D_WAIT,
        S_EMIT
    } seq_state_t;

endpackage

`default_nettype wire

/* rtl/graph_traversal_engine.sv */
`default_nettype none

// Channel   Handshake                Payload
// cmd       cmd_valid / cmd_stall    cmd_t: operation, src_vertex, dest_vertex
// res       res_valid / res_stall    res_t: vertex, last, status
// cfg       cfg_we                   cfg_data: traversal order (0 BFS, 1 DFS)
//
// A traversal walks the adjacency memory through its single read port, then emits the
// reached vertices in visit order with the last one flagged. rst_n is asynchronous; it
// empties every adjacency row and sets breadth-first order. A stalled result holds the
// sequencer in place.

module graph_traversal_engine
    import gte_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cmd_valid,
    output logic      cmd_stall,
    input  wire cmd_t cmd,
    output logic      res_valid,
    input  wire logic res_stall,
    output res_t      res,
    input  wire logic cfg_we,
    input  wire logic cfg_data
);

    logic          order_reg;
    logic          res_valid_reg;
    res_t          res_reg;
    logic          out_free;
    logic          push;
    res_t          push_res;
    adj_req_t      mem_req;
    logic [VW-1:0] rd_data;

    assign out_free = !res_valid_reg || !res_stall;

    gte_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_stall (cmd_stall),
        .order     (order_reg),
        .out_free  (out_free),
        .push      (push),
        .push_res  (push_res),
        .mem_req   (mem_req),
        .rd_data   (rd_data)
    );

    gte_adj_mem u_mem (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                order_reg <= cfg_data;
            end
            if (push)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            res_reg <= push_res;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

/* rtl/gte_adj_mem.sv */
`default_nettype none

module gte_adj_mem
    import gte_pkg::*;
(
    input  wire logic     clk,
    input  wire adj_req_t req,
    output logic [VW-1:0] rd_data
);

    logic [VW-1:0] mem [NV*NV];
    logic [VW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rd_data_reg <= mem[req.raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* rtl/gte_seq.sv */
`default_nettype none

module gte_seq
    import gte_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    input  wire cmd_t          cmd,
    output logic               cmd_stall,
    input  wire logic          order,
    input  wire logic          out_free,
    output logic               push,
    output res_t               push_res,
    output adj_req_t           mem_req,
    input  wire logic [VW-1:0] rd_data
);

    seq_state_t    state_reg, state_next;
    logic [CW-1:0] cnt_reg [NV];
    logic [CW-1:0] cnt_next [NV];
    logic [NV-1:0] visited_reg, visited_next;
    logic [VW-1:0] vlist_reg [NV];
    logic [VW-1:0] vlist_next [NV];
    stk_t          stk_reg [NV];
    stk_t          stk_next [NV];
    logic [CW-1:0] vlen_reg, vlen_next;
    logic [CW-1:0] head_reg, head_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] sp_reg, sp_next;
    logic [VW-1:0] cur_reg, cur_next;
    logic          pend_reg, pend_next;
    logic          status_reg, status_next;

    logic [CW-1:0] sp_dec;
    logic [VW-1:0] sp_top;
    stk_t          top;
    logic [VW-1:0] cnt_idx;
    logic [CW-1:0] cnt_rd;
    logic [CW-1:0] head_inc;
    logic          emit_last;

    assign sp_dec    = sp_reg - 1'b1;
    assign sp_top    = sp_dec[VW-1:0];
    assign top       = stk_reg[sp_top];
    assign head_inc  = head_reg + 1'b1;
    assign emit_last = (head_inc == vlen_reg);
    assign cmd_stall = (state_reg != S_IDLE);

    always_comb
    begin
        case (state_reg)
            S_B_SCAN: cnt_idx = cur_reg;
            S_D_TOP:  cnt_idx = top.v;
            default:  cnt_idx = cmd.src_vertex;
        endcase
    end

    assign cnt_rd = cnt_reg[cnt_idx];

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        visited_next = visited_reg;
        vlist_next   = vlist_reg;
        stk_next     = stk_reg;
        vlen_next    = vlen_reg;
        head_next    = head_reg;
        idx_next     = idx_reg;
        sp_next      = sp_reg;
        cur_next     = cur_reg;
        pend_next    = pend_reg;
        status_next  = status_reg;
        push         = 1'b0;
        push_res     = '0;
        mem_req      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.operation)
                        OP_CLEAR:
                        begin
                            for (int k = 0; k < NV; k++)
                            begin
                                cnt_next[k] = '0;
                            end
                        end
                        OP_ADD:
                        begin
                            if (cnt_rd < ROW_FULL)
                            begin
                                mem_req.we             = 1'b1;
                                mem_req.waddr          = {cmd.src_vertex, cnt_rd[VW-1:0]};
                                mem_req.wdata          = cmd.dest_vertex;
                                cnt_next[cmd.src_vertex] = cnt_rd + 1'b1;
                                status_next            = 1'b0;
                            end
                            else
                            begin
                                status_next = 1'b1;
                            end
                            state_next = S_ADD;
                        end
                        OP_TRAVERSE:
                        begin
                            visited_next                 = '0;
                            visited_next[cmd.src_vertex] = 1'b1;
                            vlist_next[0]                = cmd.src_vertex;
                            vlen_next                    = CW'(1);
                            head_next                    = '0;
                            if (order)
                            begin
                                stk_next[0] = '{v: cmd.src_vertex, nxt: '0};
                                sp_next     = CW'(1);
                                state_next  = S_D_TOP;
                            end
                            else
                            begin
                                state_next = S_B_NEXT;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_ADD:
            begin
                if (out_free)
                begin
                    push       = 1'b1;
                    push_res   = '{vertex: '0, last: 1'b1, status: status_reg};
                    state_next = S_IDLE;
                end
            end

            S_B_NEXT:
            begin
                if (head_reg == vlen_reg)
                begin
                    head_next  = '0;
                    state_next = S_EMIT;
                end
                else
                begin
                    cur_next   = vlist_reg[head_reg[VW-1:0]];
                    head_next  = head_inc;
                    idx_next   = '0;
                    pend_next  = 1'b0;
                    state_next = S_B_SCAN;
                end
            end

            S_B_SCAN:
            begin
                // The read issued last cycle is checked while the next one goes out.
                if (pend_reg && !visited_reg[rd_data])
                begin
                    visited_next[rd_data]         = 1'b1;
                    vlist_next[vlen_reg[VW-1:0]]  = rd_data;
                    vlen_next                     = vlen_reg + 1'b1;
                end
                if (idx_reg != cnt_rd)
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = {cur_reg, idx_reg[VW-1:0]};
                    idx_next      = idx_reg + 1'b1;
                    pend_next     = 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = S_B_NEXT;
                end
            end

            S_D_TOP:
            begin
                if (sp_reg == '0)
                begin
                    head_next  = '0;
                    state_next = S_EMIT;
                end
                else if (top.nxt < cnt_rd)
                begin
                    mem_req.re           = 1'b1;
                    mem_req.raddr        = {top.v, top.nxt[VW-1:0]};
                    stk_next[sp_top].nxt = top.nxt + 1'b1;
                    state_next           = S_D_WAIT;
                end
                else
                begin
                    sp_next = sp_dec;
                end
            end

            S_D_WAIT:
            begin
                if (!visited_reg[rd_data])
                begin
                    visited_next[rd_data]          = 1'b1;
                    vlist_next[vlen_reg[VW-1:0]]   = rd_data;
                    vlen_next                      = vlen_reg + 1'b1;
                    stk_next[sp_reg[VW-1:0]]       = '{v: rd_data, nxt: '0};
                    sp_next                        = sp_reg + 1'b1;
                end
                state_next = S_D_TOP;
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    push      = 1'b1;
                    push_res  = '{vertex: vlist_reg[head_reg[VW-1:0]],
                                  last: emit_last, status: 1'b0};
                    head_next = head_inc;
                    if (emit_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            visited_reg <= '0;
            vlen_reg    <= '0;
            head_reg    <= '0;
            idx_reg     <= '0;
            sp_reg      <= '0;
            pend_reg    <= 1'b0;
            for (int k = 0; k < NV; k++)
            begin
                cnt_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            visited_reg <= visited_next;
            vlen_reg    <= vlen_next;
            head_reg    <= head_next;
            idx_reg     <= idx_next;
            sp_reg      <= sp_next;
            pend_reg    <= pend_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vlist_reg  <= vlist_next;
        stk_reg    <= stk_next;
        cur_reg    <= cur_next;
        status_reg <= status_next;
    end

    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= CW'(NV))
        else $error("stack pointer beyond depth");

    a_list_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (vlen_reg <= CW'(NV)) && (head_reg <= vlen_reg))
        else $error("visit list index out of range");

    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> out_free)
        else $error("result pushed into a full output register");

    a_pend_read: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> $past(mem_req.re))
        else $error("pending adjacency data without a read");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_res.last) |=> (state_reg == S_IDLE))
        else $error("sequencer busy after final result");

endmodule

`default_nettype wire
